[hw/rtl/tmq_pkg.sv]
// Shared types and constants for the task mailbox queue.
package tmq_pkg;

  localparam int unsigned OPC_W      = 3;
  localparam int unsigned TASK_ID_W  = 8;
  localparam int unsigned HND_W      = 16;
  localparam int unsigned FLAG_W     = 16;
  localparam int unsigned BIT_W      = 4;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned FQ_DEPTH   = 2;
  localparam int unsigned FQ_PTR_W   = $clog2(FQ_DEPTH);
  localparam int unsigned FQ_LVL_W   = $clog2(FQ_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_SEND,
    KIND_PUSH,
    KIND_RECV,
    KIND_SET,
    KIND_CLR,
    KIND_NOP
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_MSG  = 2'd1,
    ST_BAD_TASK = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    kind_e                  kind;
    logic                   task_ok;
    logic                   hnd_null;
    logic [TASK_ID_W-1:0]   task_id;
    logic [HND_W-1:0]       handle;
    logic [FLAG_W-1:0]      bits;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fq_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bk_stat_t;

endpackage

[hw/rtl/task_mailbox_queue_core.sv]
// Top level of the task mailbox queue: front decode, command queue, back end.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser: opcode; tdata: task, handle, flags
//  m_axis    out  tvalid/tready          tdata: status, handle, flags, more
//  cfg       in   cfg_we_i (no wait)     cfg_wdata_i: message bit position
//
// In the back end, state BK_IDLE reads the event word and registers the task
// match vector, and state BK_EXEC updates queue, word and result.
// Reset empties the queue, zeroes all event words and sets the message bit to 15.
// A waiting result blocks the back end only; the front keeps filling its
// two-entry command queue until that is full.
module task_mailbox_queue_core #(
  parameter int unsigned NUM_TASKS   = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] task_id, [23:8] msg_handle, [39:24] flag_bits
  input  logic [tmq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [2:0] opcode
  input  logic [tmq_pkg::OPC_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] status, [17:2] got_handle, [33:18] task_flags, [34] more_waiting
  output logic [tmq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [tmq_pkg::BIT_W-1:0]       cfg_wdata_i
);
  import tmq_pkg::*;

  cmd_t     fe_cmd, fq_cmd;
  logic     fe_push, fq_valid, bk_pop;
  fq_stat_t fq_stat;
  bk_stat_t bk_stat;

  tmq_front #(
    .NUM_TASKS (NUM_TASKS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .fq_stat_i     (fq_stat),
    .push_o        (fe_push),
    .cmd_o         (fe_cmd)
  );

  tmq_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .cmd_i   (fe_cmd),
    .pop_i   (bk_pop),
    .cmd_o   (fq_cmd),
    .valid_o (fq_valid),
    .stat_o  (fq_stat)
  );

  tmq_back #(
    .NUM_TASKS   (NUM_TASKS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (fq_cmd),
    .cmd_valid_i   (fq_valid),
    .pop_o         (bk_pop),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .stat_o        (bk_stat)
  );

  a_fq_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fq_stat.full && fq_stat.empty))
    else $error("command queue both full and empty");

  a_more_has_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[34]) |-> (m_axis_tdata[17:2] != '0))
    else $error("more waiting without a received handle");

  a_handle_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[17:2] != '0)) |-> (m_axis_tdata[1:0] == ST_OK))
    else $error("received handle with failing status");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_axis_tvalid) && (m_axis_tdata[1:0] == ST_FULL)) |-> bk_stat.full)
    else $error("queue full reported while not full");

  a_more_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_axis_tvalid) && m_axis_tdata[34]) |-> !bk_stat.empty)
    else $error("more waiting reported on empty queue");

endmodule

[hw/rtl/tmq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tmq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tmq_front.sv]
// Input side: accept items and classify them into commands.
module tmq_front #(
  parameter int unsigned NUM_TASKS = 8
) (
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tmq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic [tmq_pkg::OPC_W-1:0]       s_axis_tuser,
  input  tmq_pkg::fq_stat_t               fq_stat_i,
  output logic                            push_o,
  output tmq_pkg::cmd_t                   cmd_o
);
  import tmq_pkg::*;

  localparam logic [OPC_W-1:0] OPC_SEND = 3'd0;
  localparam logic [OPC_W-1:0] OPC_PUSH = 3'd1;
  localparam logic [OPC_W-1:0] OPC_RECV = 3'd2;
  localparam logic [OPC_W-1:0] OPC_SET  = 3'd3;
  localparam logic [OPC_W-1:0] OPC_CLR  = 3'd4;

  logic [TASK_ID_W-1:0] task_id;
  kind_e                kind;

  assign task_id = s_axis_tdata[TASK_ID_W-1:0];

  always_comb begin
    case (s_axis_tuser)
      OPC_SEND: kind = KIND_SEND;
      OPC_PUSH: kind = KIND_PUSH;
      OPC_RECV: kind = KIND_RECV;
      OPC_SET:  kind = KIND_SET;
      OPC_CLR:  kind = KIND_CLR;
      default:  kind = KIND_NOP;
    endcase
  end

  always_comb begin
    cmd_o.kind     = kind;
    cmd_o.task_ok  = ({1'b0, task_id} < (TASK_ID_W + 1)'(NUM_TASKS));
    cmd_o.task_id  = task_id;
    cmd_o.handle   = s_axis_tdata[TASK_ID_W +: HND_W];
    cmd_o.bits     = s_axis_tdata[TASK_ID_W + HND_W +: FLAG_W];
    cmd_o.hnd_null = (cmd_o.handle == '0);
  end

  assign s_axis_tready = !fq_stat_i.full;
  assign push_o        = s_axis_tvalid && s_axis_tready;

endmodule

[hw/rtl/tmq_cmd_fifo.sv]
// Short command queue between the front and back parts.
module tmq_cmd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tmq_pkg::cmd_t      cmd_i,
  input  logic               pop_i,
  output tmq_pkg::cmd_t      cmd_o,
  output logic               valid_o,
  output tmq_pkg::fq_stat_t  stat_o
);
  import tmq_pkg::*;

  cmd_t                slot_q [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FQ_LVL_W-1:0] lvl_q, lvl_d;
  logic                do_push, do_pop;

  assign do_push = push_i && (lvl_q != FQ_LVL_W'(FQ_DEPTH));
  assign do_pop  = pop_i && (lvl_q != '0);

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    lvl_d    = lvl_q;
    if (do_push && !do_pop) begin
      lvl_d = lvl_q + 1'b1;
    end else if (!do_push && do_pop) begin
      lvl_d = lvl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      lvl_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      lvl_q    <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o        = slot_q[rd_ptr_q];
  assign valid_o      = (lvl_q != '0);
  assign stat_o.full  = (lvl_q == FQ_LVL_W'(FQ_DEPTH));
  assign stat_o.empty = (lvl_q == '0);

endmodule

[hw/rtl/tmq_back.sv]
// Execution side: message queue, event words and the result register.
module tmq_back #(
  parameter int unsigned NUM_TASKS   = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tmq_pkg::cmd_t                   cmd_i,
  input  logic                            cmd_valid_i,
  output logic                            pop_o,
  input  logic                            cfg_we_i,
  input  logic [tmq_pkg::BIT_W-1:0]       cfg_wdata_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tmq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output tmq_pkg::bk_stat_t               stat_o
);
  import tmq_pkg::*;

  localparam int unsigned TASK_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);

  bk_state_e           state_q, state_d;
  cmd_t                cmd_q;
  logic [BIT_W-1:0]    msg_bit_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [QUEUE_DEPTH-1:0] match_q, match_d;
  logic [NUM_TASKS-1:0]   evt_vld_q;

  logic [HND_W-1:0]  ent_hnd_q [QUEUE_DEPTH];
  logic [TASK_W-1:0] ent_tsk_q [QUEUE_DEPTH];
  logic [HND_W-1:0]  ent_hnd_d [QUEUE_DEPTH];
  logic [TASK_W-1:0] ent_tsk_d [QUEUE_DEPTH];
  logic [HND_W-1:0]  up_hnd [QUEUE_DEPTH];
  logic [TASK_W-1:0] up_tsk [QUEUE_DEPTH];
  logic [HND_W-1:0]  dn_hnd [QUEUE_DEPTH];
  logic [TASK_W-1:0] dn_tsk [QUEUE_DEPTH];

  logic [TASK_W-1:0] head_tidx, tidx;
  logic              ram_re, ram_we;
  logic [FLAG_W-1:0] ram_rdata, cur_word, new_word, msg_mask;
  logic [QUEUE_DEPTH-1:0] first, below;
  logic              found, more, full, ok_enq, exec_done;
  logic [HND_W-1:0]  got;
  status_e           status;

  logic                  out_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign head_tidx = cmd_i.task_id[TASK_W-1:0];
  assign tidx      = cmd_q.task_id[TASK_W-1:0];

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    ram_re    = 1'b0;
    exec_done = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && (!out_vld_q || m_axis_tready)) begin
          pop_o   = 1'b1;
          ram_re  = 1'b1;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        exec_done = 1'b1;
        state_d   = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match_d[i] = (CNT_W'(i) < cnt_q) && (ent_tsk_q[i] == head_tidx);
    end
  end

  tmq_ram #(
    .WIDTH (FLAG_W),
    .DEPTH (NUM_TASKS)
  ) u_evt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tidx),
    .wdata_i (new_word),
    .re_i    (ram_re),
    .raddr_i (head_tidx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    msg_mask = FLAG_W'(1) << msg_bit_q;
    cur_word = evt_vld_q[tidx] ? ram_rdata : '0;
    first    = match_q & (~match_q + QUEUE_DEPTH'(1));
    below    = first - QUEUE_DEPTH'(1);
    found    = |match_q;
    more     = |(match_q & ~first);
    full     = (cnt_q >= CNT_W'(QUEUE_DEPTH));
    ok_enq   = !cmd_q.hnd_null && cmd_q.task_ok && !full;
    got      = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      got = got | ({HND_W{first[i]}} & ent_hnd_q[i]);
    end
  end

  always_comb begin
    up_hnd[0] = cmd_q.handle;
    up_tsk[0] = tidx;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      up_hnd[i] = ent_hnd_q[i-1];
      up_tsk[i] = ent_tsk_q[i-1];
    end
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      dn_hnd[i] = ent_hnd_q[i+1];
      dn_tsk[i] = ent_tsk_q[i+1];
    end
    dn_hnd[QUEUE_DEPTH-1] = ent_hnd_q[QUEUE_DEPTH-1];
    dn_tsk[QUEUE_DEPTH-1] = ent_tsk_q[QUEUE_DEPTH-1];
  end

  always_comb begin
    status   = ST_OK;
    new_word = cur_word;
    cnt_d    = cnt_q;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ent_hnd_d[i] = ent_hnd_q[i];
      ent_tsk_d[i] = ent_tsk_q[i];
    end
    case (cmd_q.kind)
      KIND_SEND, KIND_PUSH: begin
        if (cmd_q.hnd_null) begin
          status = ST_BAD_MSG;
        end else if (!cmd_q.task_ok) begin
          status = ST_BAD_TASK;
        end else if (full) begin
          status = ST_FULL;
        end
        if (ok_enq) begin
          cnt_d    = cnt_q + 1'b1;
          new_word = cur_word | msg_mask;
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (cmd_q.kind == KIND_PUSH) begin
              ent_hnd_d[i] = up_hnd[i];
              ent_tsk_d[i] = up_tsk[i];
            end else if (CNT_W'(i) == cnt_q) begin
              ent_hnd_d[i] = cmd_q.handle;
              ent_tsk_d[i] = tidx;
            end
          end
        end
      end
      KIND_RECV: begin
        if (!cmd_q.task_ok) begin
          status = ST_BAD_TASK;
        end else begin
          new_word = more ? (cur_word | msg_mask) : (cur_word & ~msg_mask);
          if (found) begin
            cnt_d = cnt_q - 1'b1;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (!below[i]) begin
                ent_hnd_d[i] = dn_hnd[i];
                ent_tsk_d[i] = dn_tsk[i];
              end
            end
          end
        end
      end
      KIND_SET, KIND_CLR: begin
        if (!cmd_q.task_ok) begin
          status = ST_BAD_TASK;
        end else if (cmd_q.kind == KIND_SET) begin
          new_word = cur_word | cmd_q.bits;
        end else begin
          new_word = cur_word & ~cmd_q.bits;
        end
      end
      default: status = ST_OK;
    endcase
  end

  assign ram_we = exec_done && cmd_q.task_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      msg_bit_q <= 4'd15;
      cnt_q     <= '0;
      evt_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        msg_bit_q <= cfg_wdata_i;
      end
      if (exec_done) begin
        cnt_q     <= cnt_d;
        out_vld_q <= 1'b1;
        if (cmd_q.task_ok) begin
          evt_vld_q[tidx] <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q   <= cmd_i;
      match_q <= match_d;
    end
    if (exec_done) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ent_hnd_q[i] <= ent_hnd_d[i];
        ent_tsk_q[i] <= ent_tsk_d[i];
      end
      out_data_q <= {5'd0,
                     (cmd_q.kind == KIND_RECV) && cmd_q.task_ok && more,
                     cmd_q.task_ok ? new_word : FLAG_W'(0),
                     (cmd_q.kind == KIND_RECV) && cmd_q.task_ok ? got : HND_W'(0),
                     status};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign stat_o.full   = full;
  assign stat_o.empty  = (cnt_q == '0);

endmodule

[tb/mailbox_checker.sv]
// Predicts each item's result and checks it against the result channel.
module mailbox_checker #(
  parameter int unsigned NUM_TASKS   = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  input  logic                            item_ready_i,
  input  logic [tmq_pkg::IN_DATA_W-1:0]   item_data_i,
  input  logic [tmq_pkg::OPC_W-1:0]       item_op_i,
  input  logic                            res_valid_i,
  input  logic                            res_ready_i,
  input  logic [tmq_pkg::OUT_DATA_W-1:0]  res_data_i,
  input  logic                            cfg_we_i,
  input  logic [tmq_pkg::BIT_W-1:0]       cfg_wdata_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import tmq_pkg::*;

  localparam logic [BIT_W-1:0] MSG_BIT_RESET = 4'd15;

  typedef struct packed {
    status_e            status;
    logic [HND_W-1:0]   handle;
    logic [FLAG_W-1:0]  flags;
    logic               more;
  } mail_reply_t;

  logic [HND_W-1:0]     queued_hnd[$];
  logic [TASK_ID_W-1:0] queued_tsk[$];
  logic [FLAG_W-1:0]    event_word [NUM_TASKS];
  logic [BIT_W-1:0]     msg_bit_pos;
  mail_reply_t          owed_replies[$];
  int                   failures = 0;

  assign fail_count_o = failures;

  task automatic report(input string what, input logic [31:0] seen, input logic [31:0] want);
    failures++;
    $display("mismatch at %0t: %s got 0x%0h, want 0x%0h", $realtime, what, seen, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [OPC_W-1:0]     opc;
    logic [TASK_ID_W-1:0] tid;
    logic [HND_W-1:0]     hnd;
    logic [FLAG_W-1:0]    bits;
    logic [FLAG_W-1:0]    mask;
    logic                 tid_ok;
    int                   first;
    int                   second;
    mail_reply_t          r;
    mail_reply_t          due;
    if (!rst_ni) begin
      queued_hnd.delete();
      queued_tsk.delete();
      owed_replies.delete();
      foreach (event_word[t]) event_word[t] = '0;
      msg_bit_pos = MSG_BIT_RESET;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        msg_bit_pos = cfg_wdata_i;
      end
      if (item_valid_i && item_ready_i) begin
        opc    = item_op_i;
        tid    = item_data_i[TASK_ID_W-1:0];
        hnd    = item_data_i[TASK_ID_W +: HND_W];
        bits   = item_data_i[TASK_ID_W+HND_W +: FLAG_W];
        tid_ok = tid < NUM_TASKS;
        mask   = FLAG_W'(1) << msg_bit_pos;
        first  = -1;
        second = -1;
        r.status = ST_OK;
        r.handle = '0;
        r.flags  = '0;
        r.more   = 1'b0;
        case (opc)
          KIND_SEND, KIND_PUSH: begin
            if (hnd == '0) begin
              r.status = ST_BAD_MSG;
            end else if (!tid_ok) begin
              r.status = ST_BAD_TASK;
            end else if (queued_hnd.size() >= QUEUE_DEPTH) begin
              r.status = ST_FULL;
            end else begin
              if (opc == KIND_PUSH) begin
                queued_hnd.push_front(hnd);
                queued_tsk.push_front(tid);
              end else begin
                queued_hnd.push_back(hnd);
                queued_tsk.push_back(tid);
              end
              event_word[tid] = event_word[tid] | mask;
            end
          end
          KIND_RECV: begin
            if (!tid_ok) begin
              r.status = ST_BAD_TASK;
            end else begin
              foreach (queued_tsk[i]) begin
                if (queued_tsk[i] == tid) begin
                  if (first < 0) first = i;
                  else if (second < 0) second = i;
                end
              end
              r.more = second >= 0;
              if (r.more) event_word[tid] = event_word[tid] | mask;
              else event_word[tid] = event_word[tid] & ~mask;
              if (first >= 0) begin
                r.handle = queued_hnd[first];
                queued_hnd.delete(first);
                queued_tsk.delete(first);
              end
            end
          end
          KIND_SET, KIND_CLR: begin
            if (!tid_ok) r.status = ST_BAD_TASK;
            else if (opc == KIND_SET) event_word[tid] = event_word[tid] | bits;
            else event_word[tid] = event_word[tid] & ~bits;
          end
          default: ;
        endcase
        if (tid_ok) r.flags = event_word[tid];
        owed_replies.push_back(r);
      end
      if (res_valid_i && res_ready_i) begin
        if (owed_replies.size() == 0) begin
          report("result with no item pending", res_data_i[31:0], '0);
        end else begin
          due = owed_replies.pop_front();
          if (res_data_i[1:0] != due.status)
            report("status", 32'(res_data_i[1:0]), 32'(due.status));
          if (res_data_i[17:2] != due.handle)
            report("got_handle", 32'(res_data_i[17:2]), 32'(due.handle));
          if (res_data_i[33:18] != due.flags)
            report("task_flags", 32'(res_data_i[33:18]), 32'(due.flags));
          if (res_data_i[34] != due.more)
            report("more_waiting", 32'(res_data_i[34]), 32'(due.more));
        end
      end
      pending_o <= owed_replies.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top: clock, reset, item stimulus, result drain and verdict.
module tb;
  import tmq_pkg::*;

  localparam int unsigned NUM_TASKS   = 8;
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 80;
  localparam int HOLD_AFTER   = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 383;
  localparam int CALM_ITEMS   = 200;
  localparam int EPISODE      = 40;
  localparam int MIX_FILL     = 0;
  localparam int MIX_DRAIN    = 1;
  localparam int MIX_EVEN     = 2;
  localparam logic [OPC_W-1:0] OPC_TOP = '1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OPC_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [BIT_W-1:0]      cfg_wdata_i = '0;
  int                    fail_count;
  int                    pending;
  int                    quiet_cycles = 0;
  int                    sent_count = 0;
  bit                    calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task_mailbox_queue_core #(
    .NUM_TASKS   (NUM_TASKS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  mailbox_checker #(
    .NUM_TASKS   (NUM_TASKS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_i (s_axis_tready),
    .item_data_i  (s_axis_tdata),
    .item_op_i    (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [OPC_W-1:0] opc, input logic [TASK_ID_W-1:0] tid,
                           input logic [HND_W-1:0] hnd, input logic [FLAG_W-1:0] bits);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= opc;
    s_axis_tdata  <= {bits, hnd, tid};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // drain the block before touching the register
  task automatic write_msg_bit(input logic [BIT_W-1:0] pos);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pos;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : drain
    int  span;
    bit  held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && sent_count >= HOLD_AFTER) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (calm || $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
        span = calm ? 1 : $urandom_range(1, 16);
        repeat (span) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [BIT_W-1:0]     bit_plan [4];
    logic [OPC_W-1:0]     opc;
    logic [OPC_W-1:0]     spare;
    logic [TASK_ID_W-1:0] tid;
    logic [HND_W-1:0]     hnd;
    logic [FLAG_W-1:0]    bits;
    int                   phase;
    int                   n;
    int                   mix;
    int                   spread;
    int                   pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        bit_plan[0] = 4'd15;
        bit_plan[1] = 4'($urandom_range(1, 14));
        bit_plan[2] = 4'd0;
        bit_plan[3] = 4'($urandom);
        write_msg_bit(4'd0);
        send_item(KIND_RECV, 8'd0,   16'h0000, 16'h0000);
        send_item(KIND_SEND, 8'd0,   16'h0000, 16'hFFFF);
        send_item(KIND_PUSH, 8'd255, 16'h0000, 16'h0000);
        send_item(KIND_SEND, 8'd255, 16'hFFFF, 16'h0000);
        send_item(KIND_PUSH, 8'd8,   16'h1234, 16'h0000);
        send_item(KIND_SEND, 8'd0,   16'hFFFF, 16'h0000);
        send_item(KIND_SEND, 8'd7,   16'h0001, 16'h0000);
        send_item(KIND_PUSH, 8'd0,   16'h8000, 16'h0000);
        send_item(KIND_SET,  8'd7,   16'h0000, 16'hFFFF);
        send_item(KIND_CLR,  8'd7,   16'h0000, 16'h00FF);
        send_item(KIND_SET,  8'd8,   16'h0000, 16'hFFFF);
        send_item(KIND_CLR,  8'd255, 16'h0000, 16'hFFFF);
        send_item(KIND_RECV, 8'd0,   16'h0000, 16'h0000);
        send_item(KIND_RECV, 8'd0,   16'h0000, 16'h0000);
        send_item(KIND_RECV, 8'd0,   16'h0000, 16'h0000);
        send_item(KIND_RECV, 8'd255, 16'h0000, 16'h0000);
        send_item(KIND_RECV, 8'd7,   16'h0000, 16'h0000);
        send_item(KIND_NOP,  8'd3,   16'hFFFF, 16'hFFFF);
        send_item(OPC_TOP,   8'd255, 16'hFFFF, 16'hFFFF);
        send_item(KIND_SET,  8'd0,   16'h0000, 16'h0000);
        send_item(KIND_CLR,  8'd0,   16'h0000, 16'hFFFF);
        for (phase = 0; phase < 4; phase++) begin
          write_msg_bit(bit_plan[phase]);
          for (n = 0; n < PHASE_ITEMS; n++) begin
            calm = (phase == 3) && (n >= PHASE_ITEMS - CALM_ITEMS);
            if (n % EPISODE == 0) begin
              mix    = $urandom_range(MIX_FILL, MIX_EVEN);
              spread = $urandom_range(0, NUM_TASKS - 1);
            end
            pick  = $urandom_range(0, 99);
            spare = OPC_W'($urandom_range(KIND_NOP, OPC_TOP));
            case (mix)
              MIX_FILL: opc = pick < 60 ? KIND_SEND : pick < 75 ? KIND_PUSH :
                              pick < 88 ? KIND_RECV : pick < 93 ? KIND_SET :
                              pick < 97 ? KIND_CLR : spare;
              MIX_DRAIN: opc = pick < 15 ? KIND_SEND : pick < 22 ? KIND_PUSH :
                               pick < 80 ? KIND_RECV : pick < 88 ? KIND_SET :
                               pick < 95 ? KIND_CLR : spare;
              default: opc = pick < 30 ? KIND_SEND : pick < 42 ? KIND_PUSH :
                             pick < 70 ? KIND_RECV : pick < 82 ? KIND_SET :
                             pick < 94 ? KIND_CLR : spare;
            endcase
            if ($urandom_range(0, 19) == 0) tid = TASK_ID_W'($urandom_range(NUM_TASKS, 255));
            else tid = TASK_ID_W'($urandom_range(0, spread));
            pick = $urandom_range(0, 24);
            hnd  = pick == 0 ? 16'h0000 : pick == 1 ? 16'hFFFF : 16'($urandom_range(1, 65535));
            pick = $urandom_range(0, 19);
            bits = pick == 0 ? 16'h0000 : pick == 1 ? 16'hFFFF : 16'($urandom);
            send_item(opc, tid, hnd, bits);
          end
        end
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
      end
      wait (quiet_cycles >= STALL_LIMIT);
    join_any
    if (quiet_cycles < STALL_LIMIT && fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tmq_pkg.sv
hw/rtl/tmq_ram.sv
hw/rtl/tmq_front.sv
hw/rtl/tmq_cmd_fifo.sv
hw/rtl/tmq_back.sv
hw/rtl/task_mailbox_queue_core.sv
tb/mailbox_checker.sv
tb/tb.sv
